>>> rtl/pso_particle_dimension_update_top_defines.svh
// Assertion macros for the RTL file that carries concurrent checks, pdu_pipe_ctrl.
// Each macro expects clk and rst_n to exist in the module that uses it.
`ifndef PSO_PARTICLE_DIMENSION_UPDATE_TOP_DEFINES_SVH
`define PSO_PARTICLE_DIMENSION_UPDATE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PDU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pdu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pdu_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int PIPE_DEPTH = 10;

    localparam int SHIFT_10  = 36;
    localparam int SHIFT_100 = 38;
    localparam logic [32:0] RECIP_10  = 33'((64'd1 << SHIFT_10) / 64'd10);
    localparam logic [31:0] RECIP_100 = 32'((64'd1 << SHIFT_100) / 64'd100);

    localparam logic [17:0] INERTIA_RESET   = 18'd32768;
    localparam logic [17:0] SOCIAL_RESET    = 18'd131072;
    localparam logic [17:0] COGNITIVE_RESET = 18'd98304;
    localparam logic [16:0] STEP_FRAC_RESET = 17'd9830;

    localparam logic [1:0] REG_INERTIA   = 2'd0;
    localparam logic [1:0] REG_SOCIAL    = 2'd1;
    localparam logic [1:0] REG_COGNITIVE = 2'd2;
    localparam logic [1:0] REG_STEP_FRAC = 2'd3;

    typedef enum logic [1:0] {
        HIT_NONE  = 2'd0,
        HIT_LOW   = 2'd1,
        HIT_BOUND = 2'd2
    } hit_t;

    typedef struct packed {
        logic [PIPE_DEPTH-1:0] load;
        logic [PIPE_DEPTH-1:0] valid;
    } pdu_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/pso_particle_dimension_update_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Updates one dimension of one particle per transaction in Q16.16 fixed point: the step
// w*v + s*r1*(gbest-x) + c*r2*(pbest-x) is clamped to U*bound and added to the position; a
// sum below zero sets it to bound/100 and one above the bound clamps it there, both reversing
// and dividing the velocity by ten. The ten-stage pipeline takes one transaction every cycle
// unless in_stall is high; an output stall holds occupied stages back to the first empty one and
// empty stages still fill. The user must write the inertia, social, cognitive and step-limit
// registers through the cfg port while no transaction is in flight; the block does not enforce it.

module pso_particle_dimension_update_top
    import pdu_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [17:0]        cfg_data,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] position,
    input  wire logic signed [31:0] velocity,
    input  wire logic signed [31:0] personal_best,
    input  wire logic signed [31:0] global_best,
    input  wire logic [30:0]        upper_bound,
    input  wire logic [16:0]        rand_social,
    input  wire logic [16:0]        rand_cognitive,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      new_position,
    output logic signed [31:0]      new_velocity,
    output logic [1:0]              boundary_hit
);

    localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

    pdu_ctrl_t ctrl;

    logic [17:0] inertia_reg;
    logic [17:0] social_reg;
    logic [17:0] cognitive_reg;
    logic [16:0] step_frac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inertia_reg   <= INERTIA_RESET;
            social_reg    <= SOCIAL_RESET;
            cognitive_reg <= COGNITIVE_RESET;
            step_frac_reg <= STEP_FRAC_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_INERTIA:   inertia_reg   <= cfg_data;
                REG_SOCIAL:    social_reg    <= cfg_data;
                REG_COGNITIVE: cognitive_reg <= cfg_data;
                REG_STEP_FRAC: step_frac_reg <= cfg_data[16:0];
                default:       inertia_reg   <= inertia_reg;
            endcase
        end
    end

    pdu_pipe_ctrl u_pipe_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .ctrl      (ctrl)
    );

    // Stage 1
    logic signed [50:0] s1_wv_reg;
    logic [34:0]        s1_sr_reg;
    logic [34:0]        s1_cr_reg;
    logic [47:0]        s1_lim_reg;
    logic signed [32:0] s1_dg_reg;
    logic signed [32:0] s1_dp_reg;
    logic signed [31:0] s1_x_reg;
    logic [30:0]        s1_bnd_reg;
    logic [31:0]        s1_n100_reg;

    // Stage 2
    logic signed [34:0] s2_tw_reg;
    logic [19:0]        s2_cs_reg;
    logic [19:0]        s2_cc_reg;
    logic [32:0]        s2_lim_reg;
    logic [63:0]        s2_m100_reg;
    logic signed [32:0] s2_dg_reg;
    logic signed [32:0] s2_dp_reg;
    logic signed [31:0] s2_x_reg;
    logic [30:0]        s2_bnd_reg;
    logic [31:0]        s2_n100_reg;

    // Stage 3
    logic signed [53:0] s3_ps_reg;
    logic signed [53:0] s3_pc_reg;
    logic [25:0]        s3_q100a_reg;
    logic signed [34:0] s3_tw_reg;
    logic [32:0]        s3_lim_reg;
    logic signed [31:0] s3_x_reg;
    logic [30:0]        s3_bnd_reg;
    logic [31:0]        s3_n100_reg;

    // Stage 4
    logic signed [38:0] s4_sraw_reg;
    logic signed [38:0] s4_sraw_next;
    logic [25:0]        s4_q100_reg;
    logic [25:0]        s4_q100_next;
    logic [32:0]        s4_lim_reg;
    logic signed [31:0] s4_x_reg;
    logic [30:0]        s4_bnd_reg;

    // Stage 5
    logic signed [33:0] s5_stp_reg;
    logic signed [33:0] s5_stp_next;
    logic [25:0]        s5_q100_reg;
    logic signed [31:0] s5_x_reg;
    logic [30:0]        s5_bnd_reg;

    // Stage 6 through 9 carry the classified result toward the output.
    logic [33:0]        s6_mag_reg;
    logic [33:0]        s6_mag_next;
    logic               s6_neg_reg;
    logic [31:0]        s6_pos_reg;
    logic signed [31:0] s6_vel_reg;
    logic signed [31:0] s6_vel_next;
    hit_t               s6_hit_reg;
    hit_t               s6_hit_next;
    logic [25:0]        s6_q100_reg;
    logic [30:0]        s6_bnd_reg;
    logic signed [34:0] s6_sum;

    logic [49:0]        s7_pl_reg;
    logic [49:0]        s7_ph_reg;
    logic [33:0]        s7_mag_reg;
    logic               s7_neg_reg;
    logic [31:0]        s7_pos_reg;
    logic signed [31:0] s7_vel_reg;
    hit_t               s7_hit_reg;
    logic [25:0]        s7_q100_reg;
    logic [30:0]        s7_bnd_reg;

    logic [30:0]        s8_q10a_reg;
    logic [30:0]        s8_q10a_next;
    logic [33:0]        s8_mag_reg;
    logic               s8_neg_reg;
    logic [31:0]        s8_pos_reg;
    logic signed [31:0] s8_vel_reg;
    hit_t               s8_hit_reg;
    logic [25:0]        s8_q100_reg;
    logic [30:0]        s8_bnd_reg;

    logic [30:0]        s9_q10_reg;
    logic [30:0]        s9_q10_next;
    logic               s9_neg_reg;
    logic [31:0]        s9_pos_reg;
    logic signed [31:0] s9_vel_reg;
    hit_t               s9_hit_reg;
    logic [25:0]        s9_q100_reg;
    logic [30:0]        s9_bnd_reg;

    logic signed [31:0] out_pos_reg;
    logic signed [31:0] out_pos_next;
    logic signed [31:0] out_vel_reg;
    logic signed [31:0] out_vel_next;
    hit_t               out_hit_reg;

    always_comb
    begin
        logic signed [38:0] rps;
        logic signed [38:0] rpc;
        logic [32:0]        r100;
        rps = 39'((s3_ps_reg + $signed(54'(HALF))) >>> FRAC_BITS);
        rpc = 39'((s3_pc_reg + $signed(54'(HALF))) >>> FRAC_BITS);
        s4_sraw_next = 39'(s3_tw_reg) + rps + rpc;
        r100 = {1'b0, s3_n100_reg} - 33'(s3_q100a_reg) * 33'd100;
        s4_q100_next = (r100 >= 33'd100) ? s3_q100a_reg + 26'd1 : s3_q100a_reg;
    end

    always_comb
    begin
        logic signed [38:0] lim_s;
        lim_s = $signed(39'(s4_lim_reg));
        if (s4_sraw_reg > lim_s)
        begin
            s5_stp_next = 34'(lim_s);
        end
        else if (s4_sraw_reg < -lim_s)
        begin
            s5_stp_next = 34'(-lim_s);
        end
        else
        begin
            s5_stp_next = 34'(s4_sraw_reg);
        end
    end

    always_comb
    begin
        logic [33:0] abs_stp;
        s6_sum = 35'(s5_x_reg) + 35'(s5_stp_reg);
        if (s6_sum < 35'sd0)
        begin
            s6_hit_next = HIT_LOW;
        end
        else if (s6_sum > $signed(35'(s5_bnd_reg)))
        begin
            s6_hit_next = HIT_BOUND;
        end
        else
        begin
            s6_hit_next = HIT_NONE;
        end
        abs_stp = s5_stp_reg[33] ? 34'(-s5_stp_reg) : 34'(s5_stp_reg);
        s6_mag_next = abs_stp + 34'd5;
        if (s5_stp_reg > 34'sh0_7FFF_FFFF)
        begin
            s6_vel_next = 32'sh7FFF_FFFF;
        end
        else if (s5_stp_reg < -34'sh0_8000_0000)
        begin
            s6_vel_next = -32'sh8000_0000;
        end
        else
        begin
            s6_vel_next = 32'(s5_stp_reg);
        end
    end

    always_comb
    begin
        logic [66:0] prod;
        prod = (67'(s7_ph_reg) << 17) + 67'(s7_pl_reg);
        s8_q10a_next = 31'(prod >> SHIFT_10);
    end

    always_comb
    begin
        logic [34:0] r10;
        r10 = 35'(s8_mag_reg) - 35'(s8_q10a_reg) * 35'd10;
        s9_q10_next = (r10 >= 35'd10) ? s8_q10a_reg + 31'd1 : s8_q10a_reg;
    end

    always_comb
    begin
        logic signed [31:0] reflect;
        reflect = s9_neg_reg ? $signed({1'b0, s9_q10_reg}) : -$signed({1'b0, s9_q10_reg});
        case (s9_hit_reg)
            HIT_LOW:
            begin
                out_pos_next = $signed(32'(s9_q100_reg));
                out_vel_next = reflect;
            end
            HIT_BOUND:
            begin
                out_pos_next = $signed({1'b0, s9_bnd_reg});
                out_vel_next = reflect;
            end
            default:
            begin
                out_pos_next = $signed(s9_pos_reg);
                out_vel_next = s9_vel_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            s1_wv_reg   <= $signed({1'b0, inertia_reg}) * velocity;
            s1_sr_reg   <= social_reg * rand_social;
            s1_cr_reg   <= cognitive_reg * rand_cognitive;
            s1_lim_reg  <= step_frac_reg * upper_bound;
            s1_dg_reg   <= global_best - position;
            s1_dp_reg   <= personal_best - position;
            s1_x_reg    <= position;
            s1_bnd_reg  <= upper_bound;
            s1_n100_reg <= {1'b0, upper_bound} + 32'd50;
        end
        if (ctrl.load[1])
        begin
            s2_tw_reg   <= 35'((s1_wv_reg + $signed(51'(HALF))) >>> FRAC_BITS);
            s2_cs_reg   <= 20'((36'(s1_sr_reg) + 36'(HALF)) >> FRAC_BITS);
            s2_cc_reg   <= 20'((36'(s1_cr_reg) + 36'(HALF)) >> FRAC_BITS);
            s2_lim_reg  <= 33'((49'(s1_lim_reg) + 49'(HALF)) >> FRAC_BITS);
            s2_m100_reg <= s1_n100_reg * RECIP_100;
            s2_dg_reg   <= s1_dg_reg;
            s2_dp_reg   <= s1_dp_reg;
            s2_x_reg    <= s1_x_reg;
            s2_bnd_reg  <= s1_bnd_reg;
            s2_n100_reg <= s1_n100_reg;
        end
        if (ctrl.load[2])
        begin
            s3_ps_reg    <= $signed({1'b0, s2_cs_reg}) * s2_dg_reg;
            s3_pc_reg    <= $signed({1'b0, s2_cc_reg}) * s2_dp_reg;
            s3_q100a_reg <= 26'(s2_m100_reg >> SHIFT_100);
            s3_tw_reg    <= s2_tw_reg;
            s3_lim_reg   <= s2_lim_reg;
            s3_x_reg     <= s2_x_reg;
            s3_bnd_reg   <= s2_bnd_reg;
            s3_n100_reg  <= s2_n100_reg;
        end
        if (ctrl.load[3])
        begin
            s4_sraw_reg <= s4_sraw_next;
            s4_q100_reg <= s4_q100_next;
            s4_lim_reg  <= s3_lim_reg;
            s4_x_reg    <= s3_x_reg;
            s4_bnd_reg  <= s3_bnd_reg;
        end
        if (ctrl.load[4])
        begin
            s5_stp_reg  <= s5_stp_next;
            s5_q100_reg <= s4_q100_reg;
            s5_x_reg    <= s4_x_reg;
            s5_bnd_reg  <= s4_bnd_reg;
        end
        if (ctrl.load[5])
        begin
            s6_mag_reg  <= s6_mag_next;
            s6_neg_reg  <= s5_stp_reg[33];
            s6_pos_reg  <= s6_sum[31:0];
            s6_vel_reg  <= s6_vel_next;
            s6_hit_reg  <= s6_hit_next;
            s6_q100_reg <= s5_q100_reg;
            s6_bnd_reg  <= s5_bnd_reg;
        end
        if (ctrl.load[6])
        begin
            s7_pl_reg   <= s6_mag_reg[16:0] * RECIP_10;
            s7_ph_reg   <= s6_mag_reg[33:17] * RECIP_10;
            s7_mag_reg  <= s6_mag_reg;
            s7_neg_reg  <= s6_neg_reg;
            s7_pos_reg  <= s6_pos_reg;
            s7_vel_reg  <= s6_vel_reg;
            s7_hit_reg  <= s6_hit_reg;
            s7_q100_reg <= s6_q100_reg;
            s7_bnd_reg  <= s6_bnd_reg;
        end
        if (ctrl.load[7])
        begin
            s8_q10a_reg <= s8_q10a_next;
            s8_mag_reg  <= s7_mag_reg;
            s8_neg_reg  <= s7_neg_reg;
            s8_pos_reg  <= s7_pos_reg;
            s8_vel_reg  <= s7_vel_reg;
            s8_hit_reg  <= s7_hit_reg;
            s8_q100_reg <= s7_q100_reg;
            s8_bnd_reg  <= s7_bnd_reg;
        end
        if (ctrl.load[8])
        begin
            s9_q10_reg  <= s9_q10_next;
            s9_neg_reg  <= s8_neg_reg;
            s9_pos_reg  <= s8_pos_reg;
            s9_vel_reg  <= s8_vel_reg;
            s9_hit_reg  <= s8_hit_reg;
            s9_q100_reg <= s8_q100_reg;
            s9_bnd_reg  <= s8_bnd_reg;
        end
        if (ctrl.load[9])
        begin
            out_pos_reg <= out_pos_next;
            out_vel_reg <= out_vel_next;
            out_hit_reg <= s9_hit_reg;
        end
    end

    assign out_valid    = ctrl.valid[PIPE_DEPTH-1];
    assign new_position = out_pos_reg;
    assign new_velocity = out_vel_reg;
    assign boundary_hit = out_hit_reg;

endmodule

`default_nettype wire

>>> rtl/pdu_pipe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "pso_particle_dimension_update_top_defines.svh"

module pdu_pipe_ctrl
    import pdu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic out_stall,
    output logic      in_stall,
    output pdu_ctrl_t ctrl
);

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic [PIPE_DEPTH-1:0] load;

    // A stage takes new contents when it is empty or when the stage after it moves.
    always_comb
    begin
        load[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || !out_stall;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int i = 1; i < PIPE_DEPTH; i++)
        begin
            if (load[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall   = !load[0];
    assign ctrl.load  = load;
    assign ctrl.valid = valid_reg;

    `PDU_ASSERT_NEXT(a_accept_fills_first, in_valid && !in_stall, valid_reg[0], "accepted transaction lost at entry")
    `PDU_ASSERT_NOW(a_no_stall_when_drained, !out_stall, !in_stall, "input stalled while output drains")
    `PDU_ASSERT_NEXT(a_first_stage_holds, valid_reg[0] && in_stall, valid_reg[0], "stalled first stage dropped its transaction")

endmodule

`default_nettype wire
